/* sv/icpnea_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpnea_pkg
// shared types, constants and arithmetic helpers of the icp normal equation
// accumulator
// ----------------------------------------------------------------------------
package icpnea_pkg;

    localparam int INPUT_FRAC_BITS = 16;
    localparam int ACC_FRAC_BITS   = 32;
    localparam int DATA_W          = 32;
    localparam int ACC_W           = 64;
    localparam int NUM_JAC         = 6;
    localparam int NUM_OPND        = NUM_JAC + 1;
    localparam int NUM_JTE_END     = NUM_JAC + 1;
    localparam int NUM_PRODUCTS    = 1 + NUM_JAC + (NUM_JAC * (NUM_JAC + 1)) / 2;
    localparam int NUM_COUNTS      = 4;
    localparam int NUM_SLOTS       = NUM_PRODUCTS + NUM_COUNTS;
    localparam int SLOT_W          = $clog2(NUM_SLOTS);
    localparam int STATUS_W        = 3;
    localparam int IN_DATA_W       = NUM_OPND * DATA_W;

    localparam int SLOT_VALID  = NUM_PRODUCTS;
    localparam int SLOT_DIST   = NUM_PRODUCTS + 1;
    localparam int SLOT_NORMAL = NUM_PRODUCTS + 2;
    localparam int SLOT_OTHER  = NUM_PRODUCTS + 3;

    localparam int CNT_VALID  = 0;
    localparam int CNT_DIST   = 1;
    localparam int CNT_NORMAL = 2;
    localparam int CNT_OTHER  = 3;

    typedef logic signed [DATA_W-1:0] opnd_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID          = 3'd0,
        ST_BAD_IN_NORMAL  = 3'd1,
        ST_OUTSIDE        = 3'd2,
        ST_BAD_REF_NORMAL = 3'd3,
        ST_DIST_REJECT    = 3'd4,
        ST_NORMAL_REJECT  = 3'd5
    } status_t;

    typedef struct packed {
        logic    adv;
        logic    live;
        logic    clear;
        status_t status;
    } acc_ctrl_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam acc_t ACC_ONE = acc_t'(1);

    // product rescale from 2*INPUT_FRAC_BITS to ACC_FRAC_BITS fraction bits
    localparam int SCALE_SHIFT = 2 * INPUT_FRAC_BITS - ACC_FRAC_BITS;
    localparam int RSHIFT      = (SCALE_SHIFT > 0) ? SCALE_SHIFT : 1;
    localparam int LSHIFT      = (SCALE_SHIFT < 0) ? -SCALE_SHIFT : 1;
    localparam acc_t ROUND_BIAS = ACC_ONE <<< (RSHIFT - 1);
    localparam acc_t SAT_LIM    = ACC_ONE <<< (ACC_W - 1 - LSHIFT);

    function automatic acc_t sat_add(acc_t a, acc_t b);
        acc_t s;
        s = a + b;
        if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]))
        begin
            s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

    // round to nearest, ties up, saturating left shift, or pass through when the fraction bits match
    function automatic acc_t scale_product(acc_t p);
        acc_t r;
        if (SCALE_SHIFT > 0)
        begin
            r = (p + ROUND_BIAS) >>> RSHIFT;
        end
        else if (SCALE_SHIFT < 0)
        begin
            if (p >= SAT_LIM)
                r = ACC_MAX;
            else if (p < -SAT_LIM)
                r = ACC_MIN;
            else
                r = p <<< LSHIFT;
        end
        else
        begin
            r = p;
        end
        return r;
    endfunction

    // operand 0 is the residual, operands 1..6 the jacobian entries
    function automatic int opnd_a_of(int slot);
        int r;
        int n;
        r = 0;
        n = NUM_JTE_END;
        if (slot >= NUM_JTE_END)
        begin
            for (int i = 0; i < NUM_JAC; i++)
            begin
                for (int k = i; k < NUM_JAC; k++)
                begin
                    if (n == slot)
                        r = i + 1;
                    n++;
                end
            end
        end
        return r;
    endfunction

    function automatic int opnd_b_of(int slot);
        int r;
        int n;
        r = slot;
        n = NUM_JTE_END;
        if (slot >= NUM_JTE_END)
        begin
            for (int i = 0; i < NUM_JAC; i++)
            begin
                for (int k = i; k < NUM_JAC; k++)
                begin
                    if (n == slot)
                        r = k + 1;
                    n++;
                end
            end
        end
        return r;
    endfunction

endpackage

/* sv/icpnea_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpnea_lane
// one product lane: multiply, rescale to q32.32, saturating accumulate
// ----------------------------------------------------------------------------
module icpnea_lane
    import icpnea_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  acc_ctrl_t ctrl,
    input  opnd_t     opnd_a,
    input  opnd_t     opnd_b,
    output acc_t      total
);

    acc_t prod_reg;
    acc_t prod_next;
    acc_t scaled_reg;
    acc_t acc_reg;
    acc_t acc_next;
    logic hit;

    assign prod_next = acc_t'(opnd_a) * acc_t'(opnd_b);
    assign hit       = ctrl.live && (ctrl.status == ST_VALID);
    assign total     = hit ? sat_add(acc_reg, scaled_reg) : acc_reg;
    assign acc_next  = ctrl.clear ? '0 : total;

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            prod_reg   <= prod_next;
            scaled_reg <= scale_product(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (ctrl.adv && ctrl.live)
            acc_reg <= acc_next;
    end

endmodule

/* sv/icpnea_count.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpnea_count
// saturating pixel counters: valid, distance reject, normal reject, other
// ----------------------------------------------------------------------------
module icpnea_count
    import icpnea_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  acc_ctrl_t ctrl,
    output acc_t      totals [NUM_COUNTS]
);

    acc_t                  cnt_reg [NUM_COUNTS];
    logic [NUM_COUNTS-1:0] inc;

    always_comb
    begin
        inc = '0;
        case (ctrl.status)
            ST_VALID:         inc[CNT_VALID]  = ctrl.live;
            ST_DIST_REJECT:   inc[CNT_DIST]   = ctrl.live;
            ST_NORMAL_REJECT: inc[CNT_NORMAL] = ctrl.live;
            default:          inc[CNT_OTHER]  = ctrl.live;
        endcase
    end

    for (genvar c = 0; c < NUM_COUNTS; c++)
    begin : g_cnt
        assign totals[c] = inc[c] ? sat_add(cnt_reg[c], ACC_ONE) : cnt_reg[c];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cnt_reg[c] <= '0;
            else if (ctrl.adv && ctrl.live)
                cnt_reg[c] <= ctrl.clear ? '0 : totals[c];
        end
    end

endmodule

/* sv/icpnea_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpnea_emit
// merge stage: snapshots all lane and count sums at frame end and shifts them out
// ----------------------------------------------------------------------------
module icpnea_emit
    import icpnea_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  acc_t              totals [NUM_SLOTS],
    output logic              busy,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [ACC_W-1:0]  m_axis_tdata,
    output logic [SLOT_W-1:0] m_axis_tuser,
    output logic              m_axis_tlast
);

    acc_t              buf_reg [NUM_SLOTS];
    logic              busy_reg;
    logic              busy_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              take;
    logic              at_end;

    assign take          = busy_reg && m_axis_tready;
    assign at_end        = (idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign busy          = busy_reg;
    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = buf_reg[0];
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = at_end;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (take)
        begin
            busy_next = !at_end;
            idx_next  = idx_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= totals;
        end
        else if (take)
        begin
            for (int n = 0; n < NUM_SLOTS - 1; n++)
                buf_reg[n] <= buf_reg[n+1];
        end
    end

endmodule

/* sv/icp_normal_equation_accumulator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icp_normal_equation_accumulator_unit
// point-to-plane icp normal equation accumulator with one lane per product
// ----------------------------------------------------------------------------
// Takes one tracked pixel request per clock while no frame end waits for
// the emit buffer. Each of the 28 product lanes multiplies, rescales to
// q32.32 and adds with saturation; a pixel passes the operand, product and
// rescale registers before it reaches its accumulators. On the last pixel
// of a frame the 32 sums are copied into a shift buffer and leave one per
// cycle while the result side is ready (error, six jte, 21 jtj, then the
// valid, distance, normal and other counts), while the next frame already
// accumulates. The last pixel of a frame waits at the accumulate stage
// until the previous frame's 32 sums have all been taken and the buffer
// has gone idle, so with the result side always ready frames of at least
// 33 pixels run at one pixel per cycle and shorter frames stall the input.
// ----------------------------------------------------------------------------
module icp_normal_equation_accumulator_unit
    import icpnea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // residual_error, jac_0 .. jac_5
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // status_code
    input  logic [STATUS_W-1:0]  s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // sum_value
    output logic [ACC_W-1:0]     m_axis_tdata,
    // sum_index
    output logic [SLOT_W-1:0]    m_axis_tuser,
    output logic                 m_axis_tlast
);

    opnd_t     opnd_reg [NUM_OPND];
    status_t   stat1_reg;
    status_t   stat2_reg;
    status_t   stat3_reg;
    logic      last1_reg;
    logic      last2_reg;
    logic      last3_reg;
    logic      v1_reg;
    logic      v2_reg;
    logic      v3_reg;
    logic      adv;
    logic      load;
    logic      emit_busy;
    acc_ctrl_t ctrl;
    acc_t      totals     [NUM_SLOTS];
    acc_t      cnt_totals [NUM_COUNTS];

    // pipeline holds only while a frame end waits for the emit buffer
    assign adv           = !(v3_reg && last3_reg && emit_busy);
    assign s_axis_tready = adv;
    assign load          = adv && v3_reg && last3_reg;

    assign ctrl.adv    = adv;
    assign ctrl.live   = v3_reg;
    assign ctrl.clear  = last3_reg;
    assign ctrl.status = stat3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int n = 0; n < NUM_OPND; n++)
                opnd_reg[n] <= s_axis_tdata[n*DATA_W +: DATA_W];
            stat1_reg <= status_t'(s_axis_tuser);
            stat2_reg <= stat1_reg;
            stat3_reg <= stat2_reg;
            last1_reg <= s_axis_tlast;
            last2_reg <= last1_reg;
            last3_reg <= last2_reg;
        end
    end

    for (genvar g = 0; g < NUM_PRODUCTS; g++)
    begin : g_lane
        icpnea_lane u_lane
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .opnd_a (opnd_reg[opnd_a_of(g)]),
            .opnd_b (opnd_reg[opnd_b_of(g)]),
            .total  (totals[g])
        );
    end

    icpnea_count u_count
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .totals (cnt_totals)
    );

    for (genvar c = 0; c < NUM_COUNTS; c++)
    begin : g_cnt_map
        assign totals[NUM_PRODUCTS + c] = cnt_totals[c];
    end

    icpnea_emit u_emit
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .totals        (totals),
        .busy          (emit_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !emit_busy)
        else $error("frame snapshot while sums still going out");

    a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (m_axis_tvalid && (m_axis_tuser == '0)))
        else $error("emission does not start at slot zero");

    a_end_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("output still valid after final slot");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no emission pending");
`endif

endmodule

/* bench/icpnea_sum_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpnea_sum_checker
// Watches both stream ports of the normal equation accumulator. Every
// accepted pixel request is folded into its own copy of the 32 frame sums.
// On the last pixel of a frame the 32 expected sums are queued and the copy
// is cleared. Each accepted result is compared field by field with the
// oldest queued sum. The mismatch count and the number of sums still
// awaited are handed to the testbench top.
// ----------------------------------------------------------------------------
module icpnea_sum_checker
    import icpnea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [STATUS_W-1:0]  s_axis_tuser,
    input  logic                 s_axis_tlast,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [ACC_W-1:0]     m_axis_tdata,
    input  logic [SLOT_W-1:0]    m_axis_tuser,
    input  logic                 m_axis_tlast,
    output int                   mismatches,
    output int                   outstanding
);

    localparam int FRAC_GAP = 2 * INPUT_FRAC_BITS - ACC_FRAC_BITS;
    localparam int DOWN_SH  = (FRAC_GAP > 0) ? FRAC_GAP : 1;
    localparam int UP_SH    = (FRAC_GAP < 0) ? -FRAC_GAP : 1;
    localparam acc_t HALF_LSB = acc_t'(1) <<< (DOWN_SH - 1);
    localparam acc_t UP_LIMIT = acc_t'(1) <<< (ACC_W - 1 - UP_SH);

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        acc_t              value;
        logic              tail;
    } sum_rec_t;

    acc_t     frame_sums [NUM_SLOTS];
    sum_rec_t expected_sums [$];
    int       errs;

    function automatic acc_t clamp_add(acc_t a, acc_t b);
        logic [ACC_W:0] wide;
        wide = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (wide[ACC_W] != wide[ACC_W-1])
            return wide[ACC_W] ? ACC_MIN : ACC_MAX;
        return wide[ACC_W-1:0];
    endfunction

    // product rescaled to q32.32
    function automatic acc_t fixed_mul(opnd_t a, opnd_t b);
        acc_t wa;
        acc_t wb;
        acc_t p;
        wa = a;
        wb = b;
        p  = wa * wb;
        if (FRAC_GAP > 0)
            return (p + HALF_LSB) >>> DOWN_SH;
        if (FRAC_GAP < 0)
        begin
            if (p >= UP_LIMIT)
                return ACC_MAX;
            if (p < -UP_LIMIT)
                return ACC_MIN;
            return p <<< UP_SH;
        end
        return p;
    endfunction

    task automatic absorb_pixel(input logic [STATUS_W-1:0] code,
                                input logic [IN_DATA_W-1:0] word,
                                input logic closes);
        opnd_t    op [NUM_OPND];
        int       slot;
        sum_rec_t rec;
        for (int n = 0; n < NUM_OPND; n++)
            op[n] = word[n*DATA_W +: DATA_W];
        case (code)
            ST_VALID:
            begin
                // residual first, so the upper triangle over all operands
                // gives error, jte and jtj in slot order
                slot = 0;
                for (int a = 0; a < NUM_OPND; a++)
                begin
                    for (int b = a; b < NUM_OPND; b++)
                    begin
                        frame_sums[slot] = clamp_add(frame_sums[slot],
                                                     fixed_mul(op[a], op[b]));
                        slot++;
                    end
                end
                frame_sums[SLOT_VALID] = clamp_add(frame_sums[SLOT_VALID], ACC_ONE);
            end
            ST_DIST_REJECT:
                frame_sums[SLOT_DIST] = clamp_add(frame_sums[SLOT_DIST], ACC_ONE);
            ST_NORMAL_REJECT:
                frame_sums[SLOT_NORMAL] = clamp_add(frame_sums[SLOT_NORMAL], ACC_ONE);
            default:
                frame_sums[SLOT_OTHER] = clamp_add(frame_sums[SLOT_OTHER], ACC_ONE);
        endcase
        if (closes)
        begin
            for (int n = 0; n < NUM_SLOTS; n++)
            begin
                rec.slot  = SLOT_W'(n);
                rec.value = frame_sums[n];
                rec.tail  = (n == NUM_SLOTS - 1);
                expected_sums.push_back(rec);
                frame_sums[n] = '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sum_rec_t want;
        if (!rst_n)
        begin
            for (int n = 0; n < NUM_SLOTS; n++)
                frame_sums[n] = '0;
            expected_sums.delete();
            errs = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_sums.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected sum: slot %0d value %h last %b",
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (m_axis_tuser !== want.slot || m_axis_tdata !== want.value ||
                        m_axis_tlast !== want.tail)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("sum mismatch: expected %0d %h %b, got %0d %h %b",
                                     want.slot, want.value, want.tail,
                                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_pixel(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            mismatches  <= errs;
            outstanding <= expected_sums.size();
        end
    end

endmodule

/* bench/icp_normal_equation_accumulator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icp_normal_equation_accumulator_unit_tb
// Drives tracked pixel requests into the normal equation accumulator: a
// directed set of frames covering operand extremes, saturation in both
// directions, every status code and single-pixel frames, then random frames
// of mixed length and content. The sender works in bursts with random gaps
// and the result side stalls in changing patterns. A separate checker
// predicts and compares the 32 sums of every frame.
// ----------------------------------------------------------------------------
module icp_normal_equation_accumulator_unit_tb;

    import icpnea_pkg::*;

    localparam logic [STATUS_W-1:0] ST_SPARE_LO = 3'd6;
    localparam logic [STATUS_W-1:0] ST_SPARE_HI = 3'd7;

    localparam opnd_t OPND_MAX      = 32'sh7fff_ffff;
    localparam opnd_t OPND_MIN      = 32'sh8000_0000;
    localparam opnd_t OPND_ALL_ONES = 32'shffff_ffff;
    localparam opnd_t ONE_Q16       = 32'sh0001_0000;
    localparam opnd_t HALF_Q16      = 32'sh0000_8000;
    localparam opnd_t MINUS_ONE_Q16 = 32'shffff_0000;

    localparam int RANDOM_PIXELS = 440;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [STATUS_W-1:0]  s_axis_tuser = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [ACC_W-1:0]     m_axis_tdata;
    logic [SLOT_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;

    int mismatches;
    int outstanding;
    int burst_left = 0;
    int sent_pixels = 0;
    int rx_mode = 0;
    int rx_phase_left = 0;

    icp_normal_equation_accumulator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    icpnea_sum_checker sum_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: always ready, random, or mostly stalled
    always @(posedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode       <= $urandom_range(0, 2);
            rx_phase_left <= $urandom_range(20, 200);
        end
        else
        begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_pixel(input logic [STATUS_W-1:0] code,
                              input logic [IN_DATA_W-1:0] word,
                              input logic closes);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= code;
        s_axis_tlast  <= closes;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_pixels++;
    endtask

    function automatic opnd_t rand_operand();
        int r;
        int v;
        r = $urandom_range(0, 19);
        if (r < 10)
        begin
            // realistic q16.16 magnitudes up to eight
            v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            return opnd_t'(v);
        end
        if (r < 17)
            return opnd_t'($urandom);
        if (r == 17)
            return OPND_MAX;
        if (r == 18)
            return OPND_MIN;
        return ($urandom_range(0, 1) == 0) ? opnd_t'(0) : OPND_ALL_ONES;
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_pixel_word();
        logic [IN_DATA_W-1:0] word;
        for (int n = 0; n < NUM_OPND; n++)
            word[n*DATA_W +: DATA_W] = rand_operand();
        return word;
    endfunction

    function automatic logic [STATUS_W-1:0] rand_status();
        case ($urandom_range(0, 15))
            9:       return ST_BAD_IN_NORMAL;
            10:      return ST_OUTSIDE;
            11:      return ST_BAD_REF_NORMAL;
            12:      return ST_DIST_REJECT;
            13:      return ST_NORMAL_REJECT;
            14:      return ST_SPARE_LO;
            15:      return ST_SPARE_HI;
            default: return ST_VALID;
        endcase
    endfunction

    initial
    begin
        int frame_len;
        int random_start;
        int drain_wait;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // single zero pixel frame
        send_pixel(ST_VALID, '0, 1'b1);

        // every product at its positive extreme, sums saturate high
        repeat (3) send_pixel(ST_VALID, {{NUM_JAC{OPND_MIN}}, OPND_MIN}, 1'b0);
        send_pixel(ST_OUTSIDE, rand_pixel_word(), 1'b1);

        // jte saturates low, then every other status code once
        repeat (3) send_pixel(ST_VALID, {{NUM_JAC{OPND_MAX}}, OPND_MIN}, 1'b0);
        send_pixel(ST_BAD_IN_NORMAL, rand_pixel_word(), 1'b0);
        send_pixel(ST_OUTSIDE, rand_pixel_word(), 1'b0);
        send_pixel(ST_BAD_REF_NORMAL, rand_pixel_word(), 1'b0);
        send_pixel(ST_NORMAL_REJECT, rand_pixel_word(), 1'b0);
        send_pixel(ST_SPARE_LO, rand_pixel_word(), 1'b0);
        send_pixel(ST_SPARE_HI, rand_pixel_word(), 1'b0);
        send_pixel(ST_DIST_REJECT, rand_pixel_word(), 1'b1);

        // frame of rejects only
        send_pixel(ST_DIST_REJECT, rand_pixel_word(), 1'b0);
        send_pixel(ST_NORMAL_REJECT, rand_pixel_word(), 1'b0);
        send_pixel(ST_NORMAL_REJECT, rand_pixel_word(), 1'b1);

        // unused code closes the frame
        send_pixel(ST_VALID, {{NUM_JAC{ONE_Q16}}, ONE_Q16}, 1'b0);
        send_pixel(ST_SPARE_HI, rand_pixel_word(), 1'b1);

        // mixed signs and single-lsb values
        send_pixel(ST_VALID, {HALF_Q16, MINUS_ONE_Q16, OPND_MIN, OPND_MAX,
                              OPND_ALL_ONES, ONE_Q16, ONE_Q16}, 1'b0);
        send_pixel(ST_VALID, {opnd_t'(1), OPND_ALL_ONES, HALF_Q16, MINUS_ONE_Q16,
                              OPND_MAX, opnd_t'(0), OPND_ALL_ONES}, 1'b0);
        send_pixel(ST_VALID, {OPND_MAX, OPND_MIN, opnd_t'(1), OPND_ALL_ONES,
                              HALF_Q16, MINUS_ONE_Q16, OPND_MAX}, 1'b1);

        random_start = sent_pixels;
        while (sent_pixels - random_start < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 9))
                0:       frame_len = $urandom_range(41, 70);
                1, 2:    frame_len = $urandom_range(13, 40);
                default: frame_len = $urandom_range(1, 12);
            endcase
            for (int n = 0; n < frame_len; n++)
                send_pixel(rand_status(), rand_pixel_word(), n == frame_len - 1);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        drain_wait = 0;
        while (outstanding != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
